[src/lsr_pkg.sv]
`default_nettype none

package lsr_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned WordW        = 32;
  localparam int unsigned CountW       = 7;
  localparam logic [CountW-1:0] CapResetVal = 7'd64;

  typedef enum logic [1:0] {
    OpPush    = 2'd0,
    OpPop     = 2'd1,
    OpPeek    = 2'd2,
    OpReverse = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic signed [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] data;
    status_e                 status;
    logic [CountW-1:0]       count;
  } out_item_t;

endpackage

`default_nettype wire

[src/lifo_stack_with_reverse.sv]
`default_nettype none
// push, pop and peek: result registered in the cycle after the transaction is accepted,
// one transaction per cycle while the output side keeps draining and no reverse is running
// reverse: floor(count / 2) swaps, each swap done in turn on the
// single read and single write port of the entry ram (read, read, write, write)
// reset: fill count cleared, capacity set to 64, entry ram contents undefined
// with no clearing pass, so the block accepts transactions straight after reset

module lifo_stack_with_reverse #(
  parameter int unsigned DEPTH = lsr_pkg::DefaultDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire lsr_pkg::in_item_t           in_data_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output lsr_pkg::out_item_t               out_data_o,
  // capacity register
  input  wire logic                        cfg_we_i,
  input  wire logic [lsr_pkg::CountW-1:0]  cfg_wdata_i
);
  import lsr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // common width for comparing the count against the capacity register
  localparam int unsigned MW = (CW > CountW) ? CW : CountW;

  // one-hot sequencer: idle, or one of the four phases of a swap
  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SRdLo = 5'b00010,
    SRdHi = 5'b00100,
    SWrLo = 5'b01000,
    SWrHi = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CountW-1:0] cap_q;
  logic [AW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [WordW-1:0]  lo_word_q;

  // output register
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              out_sel_q, out_sel_d;    // data comes from the ram read register

  // ram ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WordW-1:0]  ram_wdata, ram_rdata;

  logic accept, full, empty, start_swap, more_swaps, finish;
  logic [AW-1:0] gap;

  // a new transaction only when idle and the output register is free or draining now
  assign in_stall_o = (state_q != SIdle) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // full against the smaller of capacity and depth
  assign full  = (MW'(count_q) >= MW'(cap_q)) || (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign start_swap = accept && (in_data_i.op == OpReverse) && (count_q > CW'(1));

  // after this swap lo moves up and hi down; carry on while they have not met
  assign gap        = hi_q - lo_q;
  assign more_swaps = ({1'b0, gap} > (AW + 1)'(2));
  assign finish     = (state_q == SWrHi) && !more_swaps;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_sel_d    = out_sel_q;
    ram_we       = 1'b0;
    ram_waddr    = lo_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = lo_q;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          out_status_d = StOk;
          out_sel_d    = 1'b0;
          out_valid_d  = 1'b1;
          unique case (in_data_i.op) inside
            OpPush: begin
              if (full) begin
                out_status_d = StFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = in_data_i.value;
                count_d   = count_q + CW'(1);
              end
            end
            OpPop, OpPeek: begin
              if (empty) begin
                out_status_d = StEmpty;
              end else begin
                // top entry lands in the ram read register for the output
                ram_re    = 1'b1;
                ram_raddr = AW'(count_q - CW'(1));
                out_sel_d = 1'b1;
                if (in_data_i.op == OpPop) begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            default: begin
              // reverse: with fewer than two entries nothing moves
              if (start_swap) begin
                out_valid_d = 1'b0;
                lo_d        = '0;
                hi_d        = AW'(count_q - CW'(1));
                state_d     = SRdLo;
              end
            end
          endcase
          out_count_d = CountW'(count_d);
        end
      end
      SRdLo: begin
        ram_re    = 1'b1;
        ram_raddr = lo_q;
        state_d   = SRdHi;
      end
      SRdHi: begin
        // low word arrives now, captured in lo_word_q
        ram_re    = 1'b1;
        ram_raddr = hi_q;
        state_d   = SWrLo;
      end
      SWrLo: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ram_rdata;
        state_d   = SWrHi;
      end
      SWrHi: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = lo_word_q;
        lo_d      = lo_q + AW'(1);
        hi_d      = hi_q - AW'(1);
        if (more_swaps) begin
          state_d = SRdLo;
        end else begin
          state_d     = SIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      cap_q       <= CapResetVal;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_sel_q    <= out_sel_d;
    if (state_q == SRdHi) begin
      lo_word_q <= ram_rdata;
    end
  end

  lsr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the read register only changes on an accepted transaction or during a swap,
  // both of which need a free output register, so a stalled result holds
  assign out_valid_o       = out_valid_q;
  assign out_data_o.data   = out_sel_q ? $signed(ram_rdata) : '0;
  assign out_data_o.status = out_status_q;
  assign out_data_o.count  = out_count_q;

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  // a swap in progress keeps the input side stalled
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall_o)
    else $error("input accepted during reverse");

  // the last swap phase hands a result to the output register
  a_swap_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && (state_q == SIdle)))
    else $error("reverse finished without a result");

  // a push that is not refused grows the stack by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.op == OpPush) && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not advance the count");

endmodule

`default_nettype wire

[src/lsr_ram.sv]
`default_nettype none

module lsr_ram #(
  parameter int unsigned DEPTH = lsr_pkg::DefaultDepth,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [lsr_pkg::WordW-1:0]  wdata_i,
  input  wire logic                       re_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [lsr_pkg::WordW-1:0]  rdata_o
);
  import lsr_pkg::*;

  logic [WordW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[verif/tb_lifo_stack_with_reverse.sv]
`timescale 1ns / 1ps

module tb_lifo_stack_with_reverse;
  import lsr_pkg::*;

  localparam int unsigned Depth         = DefaultDepth;
  // a full reverse runs 32 swaps and the receiver may stall on top of that
  localparam int unsigned WatchdogLimit = 5000;
  // cycles left to settle once every expected result has been seen
  localparam int unsigned SettleCycles  = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CountW-1:0]    cfg_wdata_i;

  // shadow copy of the stack, updated at each accepted transaction
  logic signed [WordW-1:0] stack_mem [Depth];
  int unsigned             stack_fill;
  logic [CountW-1:0]       stack_cap;
  out_item_t               stack_results_q [$];

  // idle and stall rates in percent, set per test
  int unsigned src_idle_pct;
  int unsigned dst_stall_pct;

  // bookkeeping for the summary and the verdict
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_reverse;
  int unsigned n_cap_writes;
  int unsigned peak_fill;
  int unsigned quiet_cycles;

  lifo_stack_with_reverse #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected result of one stack operation, applied to the shadow stack
  function automatic void predict_stack_op(in_item_t item);
    out_item_t               res;
    int unsigned             eff_cap;
    int unsigned             i;
    logic signed [WordW-1:0] tmp;
    eff_cap    = (stack_cap > Depth) ? Depth : stack_cap;
    res.data   = '0;
    res.status = StOk;
    case (item.op)
      OpPush: begin
        if (stack_fill >= eff_cap) begin
          res.status = StFull;
          n_full++;
        end else begin
          stack_mem[stack_fill] = item.value;
          stack_fill++;
        end
      end
      OpPop: begin
        if (stack_fill == 0) begin
          res.status = StEmpty;
          n_empty++;
        end else begin
          stack_fill--;
          res.data = stack_mem[stack_fill];
        end
      end
      OpPeek: begin
        if (stack_fill == 0) begin
          res.status = StEmpty;
          n_empty++;
        end else begin
          res.data = stack_mem[stack_fill - 1];
        end
      end
      default: begin
        // bottom and top trade places, working inwards
        for (i = 0; i < stack_fill / 2; i++) begin
          tmp                            = stack_mem[i];
          stack_mem[i]                   = stack_mem[stack_fill - 1 - i];
          stack_mem[stack_fill - 1 - i]  = tmp;
        end
        n_reverse++;
      end
    endcase
    res.count = CountW'(stack_fill);
    if (stack_fill > peak_fill) peak_fill = stack_fill;
    stack_results_q.push_back(res);
  endfunction

  // input side monitor: predicts on every accepted transaction, tracks capacity writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_stack_op(in_data_i);
        n_sent++;
      end
      if (cfg_we_i) begin
        stack_cap = cfg_wdata_i;
        n_cap_writes++;
      end
    end
  end

  // output side: each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stack_results_q.size() == 0) begin
        $error("result with nothing expected: data %0d status %0d count %0d",
               out_data_o.data, out_data_o.status, out_data_o.count);
        n_errors++;
      end else begin
        exp_res = stack_results_q.pop_front();
        n_checked++;
        if (out_data_o.data !== exp_res.data) begin
          $error("data mismatch: expected %0d, actual %0d", exp_res.data, out_data_o.data);
          n_errors++;
        end
        if (out_data_o.status !== exp_res.status) begin
          $error("status mismatch: expected %s, actual %0d",
                 exp_res.status.name(), out_data_o.status);
          n_errors++;
        end
        if (out_data_o.count !== exp_res.count) begin
          $error("count mismatch: expected %0d, actual %0d", exp_res.count, out_data_o.count);
          n_errors++;
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < dst_stall_pct);
  end

  // watchdog: too long without any transaction on either side ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             quiet_cycles, stack_results_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one stack operation: random idle gap, then hold until accepted
  // valid is left high on return so back-to-back transactions need no gap
  task automatic send_txn(op_e op, logic signed [WordW-1:0] value);
    in_item_t item;
    item.op    = op;
    item.value = value;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (stack_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // capacity is only written with the block idle
  task automatic write_capacity(logic [CountW-1:0] cap);
    settle_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // mostly full-range words, with the corner values mixed in
  function automatic logic signed [WordW-1:0] random_word();
    case ($urandom_range(11))
      0:       return {1'b0, {(WordW-1){1'b1}}};
      1:       return {1'b1, {(WordW-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // empty-stack refusals, single-entry reverse, extreme words and a four-entry reverse
  task automatic test_basic_ops();
    send_txn(OpPop, random_word());
    send_txn(OpPeek, random_word());
    send_txn(OpReverse, random_word());
    send_txn(OpPush, {1'b0, {(WordW-1){1'b1}}});
    send_txn(OpReverse, random_word());
    send_txn(OpPeek, '0);
    send_txn(OpPush, {1'b1, {(WordW-1){1'b0}}});
    send_txn(OpPush, '1);
    send_txn(OpPush, '0);
    send_txn(OpReverse, '1);
    send_txn(OpPeek, '0);
    send_txn(OpPop, '0);
    send_txn(OpPop, '1);
    send_txn(OpPop, '0);
    send_txn(OpPop, '0);
  endtask

  // capacity zero, capacity one, and capacity dropped below the current fill
  task automatic test_capacity_edges();
    write_capacity('0);
    send_txn(OpPush, random_word());
    write_capacity(CountW'(1));
    send_txn(OpPush, random_word());
    send_txn(OpPush, random_word());
    send_txn(OpPop, random_word());
    write_capacity(CountW'(2));
    send_txn(OpPush, random_word());
    send_txn(OpPush, random_word());
    send_txn(OpPush, random_word());
    write_capacity(CountW'(1));
    send_txn(OpPush, random_word());
    send_txn(OpPeek, random_word());
    send_txn(OpReverse, random_word());
    send_txn(OpPop, random_word());
    send_txn(OpPop, random_word());
  endtask

  // random traffic in fill and drain runs so the stack reaches both full and empty,
  // with a share of fully random operations as noise
  task automatic test_random_traffic(int unsigned n_txn, int unsigned src_pct,
                                     int unsigned dst_pct, logic [CountW-1:0] cap);
    int unsigned k;
    int unsigned roll;
    int unsigned eff_cap;
    bit          filling;
    op_e         op;
    write_capacity(cap);
    src_idle_pct  = src_pct;
    dst_stall_pct = dst_pct;
    filling       = 1'b1;
    for (k = 0; k < n_txn; k++) begin
      eff_cap = (stack_cap > Depth) ? Depth : stack_cap;
      if (stack_fill >= eff_cap && $urandom_range(2) == 0) begin
        filling = 1'b0;
      end else if (stack_fill == 0 && $urandom_range(2) == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(49) == 0) begin
        filling = !filling;
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
        op = op_e'($urandom_range(3));
      end else if (filling) begin
        op = (roll < 80) ? OpPush : (roll < 88) ? OpPeek : (roll < 95) ? OpPop : OpReverse;
      end else begin
        op = (roll < 75) ? OpPop : (roll < 85) ? OpPush : (roll < 93) ? OpPeek : OpReverse;
      end
      send_txn(op, random_word());
    end
  endtask

  initial begin
    // every input known from time zero
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    n_errors      = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_full        = 0;
    n_empty       = 0;
    n_reverse     = 0;
    n_cap_writes  = 0;
    peak_fill     = 0;
    quiet_cycles  = 0;
    stack_fill    = 0;
    stack_cap     = CapResetVal;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part runs at the reset capacity first
    test_basic_ops();
    test_capacity_edges();

    // random part: one idling mode per phase, capacity changed with the stack left as is
    test_random_traffic(200, 0, 0, CountW'(127));
    test_random_traffic(200, 72, 0, CountW'($urandom_range(16, 1)));
    test_random_traffic(200, 0, 72, CountW'(Depth));
    test_random_traffic(200, 8, 8, CountW'($urandom_range(126, Depth + 1)));

    settle_idle();
    $display("stack run: %0d transactions in, %0d results checked, %0d capacity writes",
             n_sent, n_checked, n_cap_writes);
    $display("  peak fill %0d, %0d full refusals, %0d empty refusals, %0d reverses",
             peak_fill, n_full, n_empty, n_reverse);
    if (n_errors == 0 && stack_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
